FILE: src/ahob_pkg.sv
// Shared constants, types and sine table builder for the harmonic oscillator bank.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package ahob_pkg;

  localparam int NOTES        = 64;
  localparam int HARMONICS    = 16;
  localparam int SINE_ENTRIES = 1024;

  // Field widths of the request and result items
  localparam int REQ_W    = 2;
  localparam int NOTE_W   = 6;
  localparam int HARM_W   = 4;
  localparam int ENV_W    = 16;
  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 24;
  localparam int PHASE_W  = 32;

  localparam int NIDX_W = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int HIDX_W = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int SLOTS  = NOTES * HARMONICS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROM_W  = $clog2(SINE_ENTRIES);
  localparam int QTR    = SINE_ENTRIES / 4;
  localparam int QTR_W  = ROM_W - 2;

  localparam logic [63:0] Q31_ONE     = 64'd2147483648;
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] Q31_MAX     = 64'd2147483647;
  localparam logic [63:0] RND31       = 64'd1 << 30;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_GAIN    = 2'd1,
    REQ_LEVEL   = 2'd2,
    REQ_STEP    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_VOLUME,
    ST_RUN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              capture;
    logic              do_write;
    logic              calc_vol;
    logic              issue;
    logic [HIDX_W-1:0] harm;
    logic              load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_advance;
    logic note_ok;
    logic pipe_busy;
  } dp_status_t;

  typedef logic [30:0] qsin_tab_t [QTR];

  // One term of the odd series, divided by its fixed coefficient with rounding
  function automatic logic [63:0] series_div(input logic [63:0] v, input int k);
    case (k)
      0:       return (v + 64'd105) / 64'd210;
      1:       return (v + 64'd78) / 64'd156;
      2:       return (v + 64'd55) / 64'd110;
      3:       return (v + 64'd36) / 64'd72;
      4:       return (v + 64'd21) / 64'd42;
      5:       return (v + 64'd10) / 64'd20;
      6:       return (v + 64'd3) / 64'd6;
      default: return v;
    endcase
  endfunction

  // sin(pi/2 * j / QTR) in Q31, clamped to 2^31-1
  function automatic logic [30:0] quarter_sin(input int j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    x  = (HALF_PI_Q31 * 64'(4 * j) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
    x2 = (x * x + RND31) >> 31;
    t  = Q31_ONE;
    for (int k = 0; k < 7; k++) begin
      v = (x2 * t + RND31) >> 31;
      v = series_div(v, k);
      t = (v >= Q31_ONE) ? 64'd0 : Q31_ONE - v;
    end
    v = (x * t + RND31) >> 31;
    if (v > Q31_MAX) begin
      v = Q31_MAX;
    end
    return v[30:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int j = 0; j < QTR; j++) begin
      tab[j] = quarter_sin(j);
    end
    return tab;
  endfunction

  localparam qsin_tab_t   QSIN_TAB = build_qsin();
  localparam logic [30:0] QSIN_TOP = quarter_sin(QTR);

endpackage

FILE: src/ahob_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on ahob_pkg for field widths.
`timescale 1ns / 1ps

interface ahob_req_if;
  logic                             valid;
  logic                             ready;
  logic [ahob_pkg::REQ_W-1:0]       req_type;
  logic [ahob_pkg::NOTE_W-1:0]      note;
  logic [ahob_pkg::HARM_W-1:0]      harmonic;
  logic [ahob_pkg::ENV_W-1:0]       envelope;
  logic [ahob_pkg::WORD_W-1:0]      write_value;

  modport source(output valid, req_type, note, harmonic, envelope, write_value,
                 input ready);
  modport sink(input valid, req_type, note, harmonic, envelope, write_value,
               output ready);
endinterface

interface ahob_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [ahob_pkg::SAMPLE_W-1:0] sample;
  logic                               is_write_ack;

  modport source(output valid, sample, is_write_ack, input ready);
  modport sink(input valid, sample, is_write_ack, output ready);
endinterface

FILE: src/ahob_ctrl.sv
// Sequencer for the oscillator bank: dispatch, harmonic issue count, drain, result.
// Depends on ahob_pkg; drives the datapath through ctrl_cmd_t only.
`timescale 1ns / 1ps

module ahob_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ahob_pkg::ctrl_cmd_t  cmd_o,
  input  ahob_pkg::dp_status_t status_i
);

  localparam logic [ahob_pkg::HIDX_W-1:0] LastHarm =
    ahob_pkg::HIDX_W'(ahob_pkg::HARMONICS - 1);

  ahob_pkg::state_e                state_q, state_d;
  logic [ahob_pkg::HIDX_W-1:0]     h_q, h_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ahob_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ahob_pkg::ST_DISPATCH;
      end
      ahob_pkg::ST_DISPATCH: begin
        if (status_i.is_advance && status_i.note_ok) state_d = ahob_pkg::ST_VOLUME;
        else state_d = ahob_pkg::ST_RESULT;
      end
      ahob_pkg::ST_VOLUME: state_d = ahob_pkg::ST_RUN;
      ahob_pkg::ST_RUN: begin
        if (h_q == LastHarm) state_d = ahob_pkg::ST_DRAIN;
      end
      ahob_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ahob_pkg::ST_RESULT;
      end
      ahob_pkg::ST_RESULT: begin
        if (out_free) state_d = ahob_pkg::ST_IDLE;
      end
      default: state_d = ahob_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.harm = h_q;
    in_ready_o = 1'b0;
    h_d        = h_q;
    case (state_q)
      ahob_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ahob_pkg::ST_DISPATCH: cmd_o.do_write = !status_i.is_advance;
      ahob_pkg::ST_VOLUME: begin
        cmd_o.calc_vol = 1'b1;
        h_d            = '0;
      end
      ahob_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        h_d         = h_q + 1'b1;
      end
      ahob_pkg::ST_RESULT: cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ahob_pkg::ST_IDLE;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/ahob_datapath.sv
// Datapath: request register, table memories, phase memory, sine lookup,
// multiply pipeline and saturating accumulator. Depends on ahob_pkg.
`timescale 1ns / 1ps

module ahob_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ahob_pkg::ctrl_cmd_t                  cmd_i,
  output ahob_pkg::dp_status_t                 status_o,
  input  logic [ahob_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ahob_pkg::NOTE_W-1:0]          note_i,
  input  logic [ahob_pkg::HARM_W-1:0]          harmonic_i,
  input  logic [ahob_pkg::ENV_W-1:0]           envelope_i,
  input  logic [ahob_pkg::WORD_W-1:0]          write_value_i,
  output logic signed [ahob_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 is_write_ack_o
);

  localparam int NW = ahob_pkg::NIDX_W;
  localparam int SW = ahob_pkg::SLOT_W;
  localparam int HW = ahob_pkg::HIDX_W;
  localparam int GW = ahob_pkg::GAIN_W;
  localparam int PW = ahob_pkg::PHASE_W;
  localparam int QW = ahob_pkg::QTR_W;
  localparam logic signed [48:0] AccMax = 49'sd2147483647;
  localparam logic signed [48:0] AccMin = -49'sd2147483648;

  // Captured request
  ahob_pkg::req_type_e          req_q;
  logic [ahob_pkg::NOTE_W-1:0]  note_q;
  logic [ahob_pkg::HARM_W-1:0]  harm_q;
  logic [ahob_pkg::ENV_W-1:0]   env_q;
  logic [ahob_pkg::WORD_W-1:0]  wv_q;

  logic [PW-1:0] phase_mem [ahob_pkg::SLOTS];
  logic [GW-1:0] level_mem [ahob_pkg::SLOTS];
  logic [GW-1:0] gain_mem  [ahob_pkg::NOTES];
  logic [PW-1:0] step_mem  [ahob_pkg::NOTES];

  logic [PW-1:0] phase_rd_q;
  logic [GW-1:0] level_rd_q;
  logic [GW-1:0] gain_rd_q;
  logic [PW-1:0] step_rd_q;

  // A row of phases reads as zero until its note has been advanced once
  logic [ahob_pkg::NOTES-1:0] row_valid_q;
  logic                       row_ok_q;

  logic [GW-1:0]  vol_q;
  logic [PW-1:0]  step_q;
  logic           a_v_q, b_v_q, c_v_q;
  logic [HW-1:0]  h_a_q;
  logic [PW-1:0]  inc_q;
  logic signed [31:0] rom_q;
  logic [31:0]    scale_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] acc_q;
  logic signed [ahob_pkg::SAMPLE_W-1:0] sample_q;
  logic           ack_q;

  logic          is_adv;
  logic          note_ok;
  logic          harm_ok;
  logic [NW-1:0] nidx;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] wr_slot;
  logic [SW-1:0] lvl_slot;
  logic [PW-1:0] mult_h;
  logic [39:0]   vol_full;
  logic [PW-1:0] ph;
  logic [ahob_pkg::ROM_W-1:0] rom_idx;
  logic [1:0]    quad;
  logic [QW-1:0] r;
  logic [QW-1:0] r_neg;
  logic [30:0]   mag;
  logic [31:0]   mag32;
  logic signed [31:0] rom_val;
  logic [47:0]   scale_full;
  logic signed [64:0] prod_full;
  logic signed [47:0] term;
  logic signed [48:0] sum;
  logic signed [31:0] acc_sat;

  function automatic logic [39:0] envelope_mul(input logic [15:0] e, input logic [23:0] g);
    return 40'(e) * 40'(g);
  endfunction

  assign is_adv   = (req_q == ahob_pkg::REQ_ADVANCE);
  assign note_ok  = int'(note_q) < ahob_pkg::NOTES;
  assign harm_ok  = int'(harm_q) < ahob_pkg::HARMONICS;
  assign nidx     = NW'(note_q);
  assign rd_slot  = SW'(note_q) * SW'(ahob_pkg::HARMONICS) + SW'(cmd_i.harm);
  assign wr_slot  = SW'(note_q) * SW'(ahob_pkg::HARMONICS) + SW'(h_a_q);
  assign lvl_slot = SW'(note_q) * SW'(ahob_pkg::HARMONICS) + SW'(harm_q);

  assign status_o.is_advance = is_adv;
  assign status_o.note_ok    = note_ok;
  assign status_o.pipe_busy  = a_v_q | b_v_q | c_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= ahob_pkg::req_type_e'(req_type_i);
      note_q <= note_i;
      harm_q <= harmonic_i;
      env_q  <= envelope_i;
      wv_q   <= write_value_i;
    end
  end

  // Per-note tables: registered read at the captured note
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && note_ok && req_q == ahob_pkg::REQ_GAIN) begin
      gain_mem[nidx] <= wv_q[GW-1:0];
    end
    if (cmd_i.do_write && note_ok && req_q == ahob_pkg::REQ_STEP) begin
      step_mem[nidx] <= wv_q;
    end
    gain_rd_q <= gain_mem[nidx];
    step_rd_q <= step_mem[nidx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write && note_ok && harm_ok && req_q == ahob_pkg::REQ_LEVEL) begin
      level_mem[lvl_slot] <= wv_q[GW-1:0];
    end
    level_rd_q <= level_mem[rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (a_v_q) begin
      phase_mem[wr_slot] <= ph + inc_q;
    end
    phase_rd_q <= phase_mem[rd_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.calc_vol) begin
      row_valid_q[nidx] <= 1'b1;
    end
  end

  assign vol_full = envelope_mul(env_q, gain_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_vol) begin
      vol_q    <= vol_full[39:16];
      step_q   <= step_rd_q;
      row_ok_q <= row_valid_q[nidx];
    end
  end

  // Issue: phase increment for harmonic h is step * (h + 1)
  assign mult_h = PW'(cmd_i.harm) + 1'b1;

  always_ff @(posedge clk_i) begin
    h_a_q <= cmd_i.harm;
    inc_q <= step_q * mult_h;
  end

  // Stage A: sine lookup by quadrant folding, scale product, phase update
  assign ph      = row_ok_q ? phase_rd_q : '0;
  assign rom_idx = ph[PW-1 -: ahob_pkg::ROM_W];
  assign quad    = rom_idx[ahob_pkg::ROM_W-1 -: 2];
  assign r       = rom_idx[QW-1:0];
  assign r_neg   = ~r + 1'b1;

  always_comb begin
    if (quad[0]) begin
      mag = (r == '0) ? ahob_pkg::QSIN_TOP : ahob_pkg::QSIN_TAB[r_neg];
    end else begin
      mag = ahob_pkg::QSIN_TAB[r];
    end
  end

  assign mag32      = {1'b0, mag};
  assign rom_val    = quad[1] ? -$signed(mag32) : $signed(mag32);
  assign scale_full = 48'(vol_q) * 48'(level_rd_q);

  always_ff @(posedge clk_i) begin
    rom_q   <= rom_val;
    scale_q <= scale_full[47:16];
  end

  // Stage B: signed sine times unsigned scale
  assign prod_full = $signed(rom_q) * $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
  end

  // Stage C: floor shift and saturating add
  assign term = prod_q[63:16];
  assign sum  = 49'(acc_q) + 49'(term);

  always_comb begin
    if (sum > AccMax) acc_sat = 32'sh7FFF_FFFF;
    else if (sum < AccMin) acc_sat = 32'sh8000_0000;
    else acc_sat = sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_vol) acc_q <= '0;
    else if (c_v_q) acc_q <= acc_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= cmd_i.issue;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_q <= (is_adv && note_ok) ? acc_q : '0;
      ack_q    <= !is_adv;
    end
  end

  assign sample_o       = sample_q;
  assign is_write_ack_o = ack_q;

endmodule

FILE: src/additive_harmonic_oscillator_bank_unit.sv
// Top level of the additive harmonic oscillator bank: controller plus datapath.
// Depends on ahob_pkg, ahob_if, ahob_ctrl and ahob_datapath.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   req_type, note, harmonic, envelope, write_value
//   res_o    out  valid/ready   sample, is_write_ack
//
// During an advance one harmonic per cycle enters the phase/level memory read
// and multiply pipeline, then pipeline stages A, B and C drain into the
// accumulator. A write passes through the dispatch and result states.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted. No clearing pass after reset:
// per-note valid bits make unadvanced phases read as zero.
`timescale 1ns / 1ps

module additive_harmonic_oscillator_bank_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ahob_req_if.sink    req_i,
  ahob_res_if.source  res_o
);

  ahob_pkg::ctrl_cmd_t  cmd;
  ahob_pkg::dp_status_t status;

  ahob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ahob_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (req_i.req_type),
    .note_i         (req_i.note),
    .harmonic_i     (req_i.harmonic),
    .envelope_i     (req_i.envelope),
    .write_value_i  (req_i.write_value),
    .sample_o       (res_o.sample),
    .is_write_ack_o (res_o.is_write_ack)
  );

  // After an accept the block is busy with that item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted on consecutive cycles");

  // The result is loaded only once the harmonic pipeline is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !status.pipe_busy)
    else $error("result loaded while pipeline busy");

  // Harmonics are issued only for an in-range advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> status.is_advance && status.note_ok)
    else $error("harmonic issued for a non-advance request");

endmodule

FILE: verif/tb.sv
// Self-checking bench for additive_harmonic_oscillator_bank_unit: an in-bench
// model predicts each sample/ack. Depends on ahob_pkg, ahob_if and the unit.
`timescale 1ns / 1ps

module tb;

  localparam int          ROM_BITS    = $clog2(ahob_pkg::SINE_ENTRIES);
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;
  localparam logic [63:0] PI_HALF_Q31 = 64'd3373259426;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << 30;
  localparam longint      SAT_HI      = 64'sd2147483647;
  localparam longint      SAT_LO      = -64'sd2147483648;
  localparam int          ITEMS_PER_PHASE = 388;

  // divisors of successive terms in the odd sine series
  localparam int unsigned SERIES_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

  typedef struct {
    ahob_pkg::req_type_e kind;
    logic [5:0]  note;
    logic [3:0]  harm;
    logic [15:0] env;
    logic [31:0] word;
  } bank_req_t;

  typedef struct {
    logic signed [31:0] sample;
    logic               ack;
  } bank_result_t;

  logic clk_i;
  logic rst_ni;

  ahob_req_if req_if ();
  ahob_res_if res_if ();

  additive_harmonic_oscillator_bank_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // mirror of the bank
  int          wave_rom  [ahob_pkg::SINE_ENTRIES];
  logic [31:0] phase_m   [ahob_pkg::NOTES*ahob_pkg::HARMONICS];
  logic [23:0] gain_m    [ahob_pkg::NOTES];
  logic [23:0] level_m   [ahob_pkg::NOTES*ahob_pkg::HARMONICS];
  logic [31:0] step_m    [ahob_pkg::NOTES];

  bank_req_t    backlog[$];
  bank_result_t due_results[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  // what the stimulus has written so far; advances only go to complete notes
  bit gain_set  [ahob_pkg::NOTES];
  bit step_set  [ahob_pkg::NOTES];
  bit level_set [ahob_pkg::NOTES*ahob_pkg::HARMONICS];
  bit listed    [ahob_pkg::NOTES];
  int ready_notes[$];
  int queued = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sin(pi/2 * r / SINE_ENTRIES) in Q31, fixed-point odd series
  function automatic logic [63:0] quarter_wave(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] d;
    x  = (PI_HALF_Q31 * r + 64'(ahob_pkg::SINE_ENTRIES / 2)) /
         64'(ahob_pkg::SINE_ENTRIES);
    x2 = (x * x + ROUND_HALF) >> 31;
    t  = ONE_Q31;
    for (int k = 0; k < 7; k++) begin
      v = (x2 * t + ROUND_HALF) >> 31;
      d = 64'(SERIES_DIV[k]);
      v = (v + d / 2) / d;
      t = (v >= ONE_Q31) ? 64'd0 : ONE_Q31 - v;
    end
    return (x * t + ROUND_HALF) >> 31;
  endfunction

  function automatic void build_wave_rom();
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    for (int i = 0; i < ahob_pkg::SINE_ENTRIES; i++) begin
      q = (64'd4 * 64'(i)) / 64'(ahob_pkg::SINE_ENTRIES);
      r = 64'd4 * 64'(i) - q * 64'(ahob_pkg::SINE_ENTRIES);
      m = q[0] ? quarter_wave(64'(ahob_pkg::SINE_ENTRIES) - r) : quarter_wave(r);
      if (m > 64'd2147483647) begin
        m = 64'd2147483647;
      end
      wave_rom[i] = (q >= 64'd2) ? -int'(m[31:0]) : int'(m[31:0]);
    end
  endfunction

  function automatic bank_result_t run_request(input bank_req_t r);
    bank_result_t res;
    longint unsigned vol;
    longint unsigned scale;
    longint acc;
    longint prod;
    logic [31:0] ph;
    int slot;
    int idx;
    res.sample = '0;
    res.ack    = 1'b1;
    case (r.kind)
      ahob_pkg::REQ_ADVANCE: begin
        res.ack = 1'b0;
        vol = (64'(r.env) * 64'(gain_m[r.note])) >> 16;
        acc = 0;
        for (int h = 0; h < ahob_pkg::HARMONICS; h++) begin
          slot  = int'(r.note) * ahob_pkg::HARMONICS + h;
          ph    = phase_m[slot];
          idx   = int'(ph >> (32 - ROM_BITS));
          scale = (vol * 64'(level_m[slot])) >> 16;
          prod  = longint'(wave_rom[idx]) * longint'(scale);
          acc   = acc + (prod >>> 16);  // floor division by 2^16
          if (acc > SAT_HI) begin
            acc = SAT_HI;
          end
          if (acc < SAT_LO) begin
            acc = SAT_LO;
          end
          phase_m[slot] = ph + step_m[r.note] * 32'(h + 1);
        end
        res.sample = 32'(acc);
      end
      ahob_pkg::REQ_GAIN: begin
        gain_m[r.note] = r.word[23:0];
      end
      ahob_pkg::REQ_LEVEL: begin
        level_m[int'(r.note) * ahob_pkg::HARMONICS + int'(r.harm)] = r.word[23:0];
      end
      default: begin
        step_m[r.note] = r.word;
      end
    endcase
    return res;
  endfunction

  function automatic bit note_ready(input int n);
    if (!gain_set[n] || !step_set[n]) begin
      return 1'b0;
    end
    for (int h = 0; h < ahob_pkg::HARMONICS; h++) begin
      if (!level_set[n*ahob_pkg::HARMONICS + h]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic push_req(input ahob_pkg::req_type_e kind, input int n, input int h,
                          input logic [15:0] env, input logic [31:0] word);
    bank_req_t r;
    r.kind = kind;
    r.note = 6'(n);
    r.harm = 4'(h);
    r.env  = env;
    r.word = word;
    backlog.push_back(r);
    queued++;
    case (kind)
      ahob_pkg::REQ_GAIN:  gain_set[n] = 1'b1;
      ahob_pkg::REQ_LEVEL: level_set[n*ahob_pkg::HARMONICS + h] = 1'b1;
      ahob_pkg::REQ_STEP:  step_set[n] = 1'b1;
      default: ;
    endcase
    if (kind != ahob_pkg::REQ_ADVANCE && !listed[n] && note_ready(n)) begin
      listed[n] = 1'b1;
      ready_notes.push_back(n);
    end
  endtask

  // Q8.16 table word; the top byte is don't-care noise
  function automatic logic [31:0] q816_word();
    logic [23:0] mag;
    case ($urandom_range(9))
      0:       mag = 24'd0;
      1:       mag = 24'hFFFFFF;
      2, 3:    mag = 24'($urandom_range(0, 'hFFF));
      4, 5, 6: mag = 24'($urandom_range(0, 'h1FFFF));
      default: mag = 24'($urandom);
    endcase
    return {8'($urandom), mag};
  endfunction

  function automatic logic [31:0] step_word();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFFFFFF;
      2, 3:    return 32'($urandom_range(0, 'hFFFFF));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] env_word();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // full table load for one note: gain, every harmonic level, step
  task automatic load_note(input int n, input bit maxed);
    push_req(ahob_pkg::REQ_GAIN, n, $urandom_range(15), env_word(),
             maxed ? 32'hFFFFFFFF : q816_word());
    for (int h = 0; h < ahob_pkg::HARMONICS; h++) begin
      push_req(ahob_pkg::REQ_LEVEL, n, h, env_word(),
               maxed ? 32'hFFFFFFFF : q816_word());
    end
    push_req(ahob_pkg::REQ_STEP, n, $urandom_range(15), env_word(),
             maxed ? 32'hFFFFFFFF : step_word());
  endtask

  task automatic run_phase(input int idle, input int stall);
    int target;
    int n;
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = queued + ITEMS_PER_PHASE;
    while (queued < target) begin
      n = $urandom_range(ahob_pkg::NOTES - 1);
      case ($urandom_range(99)) inside
        [0:11]:  load_note(n, 1'b0);
        [12:61]: begin
          if (ready_notes.size() != 0) begin
            push_req(ahob_pkg::REQ_ADVANCE,
                     ready_notes[$urandom_range(ready_notes.size() - 1)],
                     $urandom_range(15), env_word(), 32'($urandom));
          end
        end
        default: begin
          case ($urandom_range(2))
            0: push_req(ahob_pkg::REQ_GAIN, n, $urandom_range(15), env_word(),
                        q816_word());
            1: push_req(ahob_pkg::REQ_LEVEL, n, $urandom_range(15), env_word(),
                        q816_word());
            default: push_req(ahob_pkg::REQ_STEP, n, $urandom_range(15), env_word(),
                              step_word());
          endcase
        end
      endcase
    end
    // hold off until the bank has answered everything; checked mid-cycle so
    // the driver and monitor updates of the last edge are settled
    while (backlog.size() != 0 || req_if.valid || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = ahob_pkg::REQ_ADVANCE;
    req_if.note         = '0;
    req_if.harmonic     = '0;
    req_if.envelope     = '0;
    req_if.write_value  = '0;
    res_if.ready        = 1'b0;
    build_wave_rom();
    for (int s = 0; s < ahob_pkg::NOTES*ahob_pkg::HARMONICS; s++) begin
      phase_m[s] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // saturated note: everything at full scale, step of minus one
    load_note(ahob_pkg::NOTES - 1, 1'b1);
    push_req(ahob_pkg::REQ_ADVANCE, ahob_pkg::NOTES - 1, 0, 16'hFFFF, 32'd0);
    push_req(ahob_pkg::REQ_ADVANCE, ahob_pkg::NOTES - 1, 15, 16'hFFFF, 32'hFFFFFFFF);
    push_req(ahob_pkg::REQ_ADVANCE, ahob_pkg::NOTES - 1, 7, 16'h0000, 32'd0);
    push_req(ahob_pkg::REQ_GAIN, ahob_pkg::NOTES - 1, 15, 16'hFFFF, 32'hFF000000);
    push_req(ahob_pkg::REQ_ADVANCE, ahob_pkg::NOTES - 1, 0, 16'hFFFF, 32'd0);

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(37, 37);

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : drive_req
    bank_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = backlog.pop_front();
        req_if.req_type    <= nxt.kind;
        req_if.note        <= nxt.note;
        req_if.harmonic    <= nxt.harm;
        req_if.envelope    <= nxt.env;
        req_if.write_value <= nxt.word;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // results are checked before the request of the same edge is predicted
  always @(posedge clk_i) begin : watch_bank
    bank_req_t    got_req;
    bank_result_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected item: sample %0d ack %0b", res_if.sample,
                     res_if.is_write_ack);
          end
        end else begin
          want = due_results.pop_front();
          if (want.sample !== res_if.sample || want.ack !== res_if.is_write_ack) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: sample exp %0d got %0d, ack exp %0b got %0b",
                       want.sample, res_if.sample, want.ack, res_if.is_write_ack);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        got_req.kind = ahob_pkg::req_type_e'(req_if.req_type);
        got_req.note = req_if.note;
        got_req.harm = req_if.harmonic;
        got_req.env  = req_if.envelope;
        got_req.word = req_if.write_value;
        due_results.push_back(run_request(got_req));
      end
    end
  end

endmodule

FILE: files.f
src/ahob_pkg.sv
src/ahob_if.sv
src/ahob_ctrl.sv
src/ahob_datapath.sv
src/additive_harmonic_oscillator_bank_unit.sv
verif/tb.sv
